// ===== design/brc_pkg.sv =====
// Shared constants and types for the binary run correlation pipeline.
package brc_pkg;

	localparam int TIME_BITS = 32;
	localparam int FRAC_BITS = 14;

	localparam int PW     = 2 * TIME_BITS;       // product of two counts
	localparam int DW     = 4 * TIME_BITS;       // denominator and squared numerator
	localparam int QW     = 2 * FRAC_BITS + 3;   // quotient bits, integer bit included
	localparam int DSTEPS = QW;                  // one quotient bit per stage
	localparam int SW     = FRAC_BITS + 2;       // root bits
	localparam int CW     = 16;                  // correlation port width
	localparam int EW     = (SW > CW) ? SW : CW; // width used for sign handling

	localparam int FRONT_STAGES = 4;
	localparam int LATENCY      = FRONT_STAGES + DSTEPS + SW + 1;

	localparam logic [CW-1:0] ONE_CODE     = CW'(EW'(1) << FRAC_BITS);
	localparam logic [CW-1:0] NEG_ONE_CODE = CW'(EW'(0) - (EW'(1) << FRAC_BITS));

	typedef struct packed {
		logic valid;
		logic zero;
		logic clamp;
		logic negative;
	} ctl_t;

endpackage

// ===== design/brc_front.sv =====
// Front end: count products, numerator magnitude, denominator and numerator square.
module brc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [brc_pkg::TIME_BITS-1:0] t,
	input  logic [brc_pkg::TIME_BITS-1:0] a,
	input  logic [brc_pkg::TIME_BITS-1:0] b,
	input  logic [brc_pkg::TIME_BITS-1:0] ab,
	output brc_pkg::ctl_t              ctl_o,
	output logic [brc_pkg::DW-1:0]     sq_o,
	output logic [brc_pkg::DW-1:0]     den_o
);
	import brc_pkg::*;

	localparam int H = TIME_BITS;

	logic [H-1:0]  ta, tb;
	ctl_t          ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [PW-1:0] pos_s1, neg_s1, p_s1, q_s1;
	logic [PW-1:0] mag_s2, dll_s2, dlh_s2, dhl_s2, dhh_s2;
	logic [PW-1:0] mll_s3, mlh_s3, mhh_s3;
	logic [DW-1:0] den_s3, den_s4, sq_s4;

	assign ta = t - a;
	assign tb = t - b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1.valid    <= start;
			ctl_s1.zero     <= (a == '0) || (b == '0) || (a == t) || (b == t);
			ctl_s1.clamp    <= (a > t) || (b > t);
			ctl_s1.negative <= 1'b0;
			ctl_s2          <= '{valid: ctl_s1.valid, zero: ctl_s1.zero,
				clamp: ctl_s1.clamp, negative: pos_s1 < neg_s1};
			ctl_s3          <= ctl_s2;
			ctl_s4          <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: four 32x32 products
		pos_s1 <= PW'(t) * PW'(ab);
		neg_s1 <= PW'(a) * PW'(b);
		p_s1   <= PW'(a) * PW'(ta);
		q_s1   <= PW'(b) * PW'(tb);
		// stage 2: magnitude, denominator partials
		mag_s2 <= (pos_s1 < neg_s1) ? (neg_s1 - pos_s1) : (pos_s1 - neg_s1);
		dll_s2 <= PW'(p_s1[H-1:0]) * PW'(q_s1[H-1:0]);
		dlh_s2 <= PW'(p_s1[H-1:0]) * PW'(q_s1[PW-1:H]);
		dhl_s2 <= PW'(p_s1[PW-1:H]) * PW'(q_s1[H-1:0]);
		dhh_s2 <= PW'(p_s1[PW-1:H]) * PW'(q_s1[PW-1:H]);
		// stage 3: denominator sum, square partials
		den_s3 <= DW'(dll_s2) + (DW'(dlh_s2) << H) + (DW'(dhl_s2) << H)
			+ (DW'(dhh_s2) << (2 * H));
		mll_s3 <= PW'(mag_s2[H-1:0]) * PW'(mag_s2[H-1:0]);
		mlh_s3 <= PW'(mag_s2[H-1:0]) * PW'(mag_s2[PW-1:H]);
		mhh_s3 <= PW'(mag_s2[PW-1:H]) * PW'(mag_s2[PW-1:H]);
		// stage 4: square sum
		sq_s4  <= DW'(mll_s3) + (DW'(mlh_s3) << (H + 1)) + (DW'(mhh_s3) << (2 * H));
		den_s4 <= den_s3;
	end

	assign ctl_o = ctl_s4;
	assign sq_o  = sq_s4;
	assign den_o = den_s4;

endmodule

// ===== design/brc_div.sv =====
// Restoring divider, one quotient bit per stage: floor(sq * 4^(F+1) / den).
module brc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  brc_pkg::ctl_t          ctl_i,
	input  logic [brc_pkg::DW-1:0] sq,
	input  logic [brc_pkg::DW-1:0] den,
	output brc_pkg::ctl_t          ctl_o,
	output logic [brc_pkg::QW-1:0] quo
);
	import brc_pkg::*;

	logic [DW:0]   trial  [DSTEPS];
	logic          ge     [DSTEPS];
	logic [DW-1:0] den_in [DSTEPS];
	logic [QW-1:0] quo_in [DSTEPS];
	ctl_t          ctl_in [DSTEPS];
	ctl_t          ctl_nx [DSTEPS];
	logic [DW-1:0] rem_s  [DSTEPS];
	logic [DW-1:0] den_s  [DSTEPS];
	logic [QW-1:0] quo_s  [DSTEPS];
	ctl_t          ctl_s  [DSTEPS];

	for (genvar k = 0; k < DSTEPS; k++) begin : g_step
		if (k == 0) begin : g_first
			assign trial[k]  = {1'b0, sq};
			assign den_in[k] = den;
			assign quo_in[k] = '0;
			assign ctl_in[k] = ctl_i;
			always_comb begin
				ctl_nx[k]       = ctl_in[k];
				// square above denominator: |r| > 1
				ctl_nx[k].clamp = ctl_in[k].clamp || (sq > den);
			end
		end else begin : g_next
			assign trial[k]  = {rem_s[k-1], 1'b0};
			assign den_in[k] = den_s[k-1];
			assign quo_in[k] = quo_s[k-1];
			assign ctl_in[k] = ctl_s[k-1];
			assign ctl_nx[k] = ctl_in[k];
		end

		assign ge[k] = trial[k] >= {1'b0, den_in[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_nx[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge[k] ? DW'(trial[k] - {1'b0, den_in[k]}) : trial[k][DW-1:0];
			den_s[k] <= den_in[k];
			quo_s[k] <= {quo_in[k][QW-2:0], ge[k]};
		end
	end

	assign ctl_o = ctl_s[DSTEPS-1];
	assign quo   = quo_s[DSTEPS-1];

endmodule

// ===== design/brc_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per stage.
module brc_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  brc_pkg::ctl_t          ctl_i,
	input  logic [brc_pkg::QW-1:0] quo,
	output brc_pkg::ctl_t          ctl_o,
	output logic [brc_pkg::SW-1:0] root
);
	import brc_pkg::*;

	localparam int RW = SW + 2;
	localparam int XW = 2 * SW;

	logic [RW-1:0] cur     [SW];
	logic [RW-1:0] trial   [SW];
	logic          ge      [SW];
	logic [RW-1:0] rem_in  [SW];
	logic [SW-1:0] root_in [SW];
	logic [XW-1:0] x_in    [SW];
	ctl_t          ctl_in  [SW];
	logic [RW-1:0] rem_s   [SW];
	logic [SW-1:0] root_s  [SW];
	logic [XW-1:0] x_s     [SW];
	ctl_t          ctl_s   [SW];

	for (genvar k = 0; k < SW; k++) begin : g_step
		if (k == 0) begin : g_first
			assign rem_in[k]  = '0;
			assign root_in[k] = '0;
			assign x_in[k]    = XW'(quo);
			assign ctl_in[k]  = ctl_i;
		end else begin : g_next
			assign rem_in[k]  = rem_s[k-1];
			assign root_in[k] = root_s[k-1];
			assign x_in[k]    = x_s[k-1];
			assign ctl_in[k]  = ctl_s[k-1];
		end

		assign cur[k]   = {rem_in[k][RW-3:0], x_in[k][XW-1 -: 2]};
		assign trial[k] = {root_in[k], 2'b01};
		assign ge[k]    = cur[k] >= trial[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else begin
				ctl_s[k] <= ctl_in[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge[k] ? (cur[k] - trial[k]) : cur[k];
			root_s[k] <= {root_in[k][SW-2:0], ge[k]};
			x_s[k]    <= {x_in[k][XW-3:0], 2'b00};
		end
	end

	assign ctl_o = ctl_s[SW-1];
	assign root  = root_s[SW-1];

endmodule

// ===== design/binary_run_correlation.sv =====
// Top level: Pearson correlation of two run indicators from four time counts.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | start, busy         | total_time, a_run_time, b_run_time, both_run_time
//  result   | done (one cycle)    | correlation (s16, 14 frac bits), clamped
//
// One beat enters per cycle; busy is held low, nothing in the pipe ever waits.
// Each result goes from its start beat through the front end, the one-bit-per-stage
// divider and square root, and the output register. Reset clears only the control
// flags along the pipe (valid, zero, clamp, negative) and done.
// The receiver cannot stall, so done is a plain strobe with no backpressure.
module binary_run_correlation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [brc_pkg::TIME_BITS-1:0] total_time,
	input  logic [brc_pkg::TIME_BITS-1:0] a_run_time,
	input  logic [brc_pkg::TIME_BITS-1:0] b_run_time,
	input  logic [brc_pkg::TIME_BITS-1:0] both_run_time,
	output logic                          done,
	output logic signed [brc_pkg::CW-1:0] correlation,
	output logic                          clamped
);
	import brc_pkg::*;

	ctl_t          ctl_f, ctl_d, ctl_r;
	logic [DW-1:0] sq, den;
	logic [QW-1:0] quo;
	logic [SW-1:0] root;
	logic [SW:0]   root_p1;
	logic [EW-1:0] mag_e, val_e;

	logic          done_q, clamped_q;
	logic [CW-1:0] corr_q;

	// products, |t*ab - a*b|, den = a(t-a)b(t-b), numerator squared
	brc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.t      (total_time),
		.a      (a_run_time),
		.b      (b_run_time),
		.ab     (both_run_time),
		.ctl_o  (ctl_f),
		.sq_o   (sq),
		.den_o  (den)
	);

	// Q = floor(r^2 * 4^(F+1)); the first stage also flags |r| > 1
	brc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_f),
		.sq     (sq),
		.den    (den),
		.ctl_o  (ctl_d),
		.quo    (quo)
	);

	// s = isqrt(Q) ~ 2r * 2^F
	brc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_d),
		.quo    (quo),
		.ctl_o  (ctl_r),
		.root   (root)
	);

	// largest res with (2res-1)^2 <= Q is (s+1)/2: round to nearest, ties up
	assign root_p1 = {1'b0, root} + (SW + 1)'(1);

	always_comb begin
		priority if (ctl_r.zero) begin
			mag_e = '0;
		end else if (ctl_r.clamp) begin
			mag_e = EW'(1) << FRAC_BITS;
		end else begin
			mag_e = EW'(root_p1[SW:1]);
		end
		val_e = ctl_r.negative ? (EW'(0) - mag_e) : mag_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_r.valid;
		end
	end

	always_ff @(posedge clk) begin
		corr_q    <= val_e[CW-1:0];
		clamped_q <= !ctl_r.zero && ctl_r.clamp;
	end

	assign busy        = 1'b0;
	assign done        = done_q;
	assign correlation = corr_q;
	assign clamped     = clamped_q;

	// every start beat comes out as a done beat, and no done beat lacks its start beat
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result missing after start beat");

	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching start beat");

	// a clamped result is exactly plus or minus one
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |-> ((correlation == ONE_CODE) || (correlation == NEG_ONE_CODE)))
		else $error("clamped result is not plus or minus one");

endmodule

// ===== tb/sv/brc_checker.sv =====
// Checker: predicts correlation results from accepted input beats and compares them.
module brc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [brc_pkg::TIME_BITS-1:0] total_time,
	input  logic [brc_pkg::TIME_BITS-1:0] a_run_time,
	input  logic [brc_pkg::TIME_BITS-1:0] b_run_time,
	input  logic [brc_pkg::TIME_BITS-1:0] both_run_time,
	input  logic                          done,
	input  logic signed [brc_pkg::CW-1:0] correlation,
	input  logic                          clamped,
	output int                            fail_count,
	output int                            pending_count,
	output int                            result_count
);
	import brc_pkg::*;

	typedef struct {
		logic [CW-1:0] corr;
		logic          clip;
	} corr_result_t;

	corr_result_t expected_corr_q[$];

	function automatic corr_result_t compute_correlation(logic [31:0] t, logic [31:0] a,
		logic [31:0] b, logic [31:0] ab);
		corr_result_t r;
		logic [63:0] pos_term, neg_term, mag;
		logic [127:0] den, sq;
		logic [255:0] lhs, rhs;
		logic [63:0] k;
		logic neg;
		logic [31:0] res, cand;
		r.corr = '0;
		r.clip = 1'b0;
		if (a == 0 || b == 0 || a == t || b == t)
			return r;
		pos_term = 64'(t) * 64'(ab);
		neg_term = 64'(a) * 64'(b);
		neg = pos_term < neg_term;
		mag = neg ? neg_term - pos_term : pos_term - neg_term;
		if (a > t || b > t) begin
			r.corr = neg ? NEG_ONE_CODE : ONE_CODE;
			r.clip = 1'b1;
			return r;
		end
		den = 128'(64'(a) * 64'(t - a)) * 128'(64'(b) * 64'(t - b));
		sq = 128'(mag) * 128'(mag);
		if (sq > den) begin
			r.corr = neg ? NEG_ONE_CODE : ONE_CODE;
			r.clip = 1'b1;
			return r;
		end
		// (mag * 2^(F+1))^2 needs more than 128 bits
		lhs = 256'(sq) << (2 * (FRAC_BITS + 1));
		res = 0;
		for (int i = FRAC_BITS; i >= 0; i--) begin
			cand = res | (32'd1 << i);
			if (cand > (32'd1 << FRAC_BITS))
				continue;
			k = 64'(2 * cand - 1);
			rhs = 256'(k * k) * 256'(den);
			if (rhs <= lhs)
				res = cand;
		end
		r.corr = neg ? CW'(-res) : CW'(res);
		return r;
	endfunction

	assign pending_count = expected_corr_q.size();

	always @(posedge clk or negedge arst_n) begin
		corr_result_t e;
		int errs;
		if (!arst_n) begin
			fail_count   <= 0;
			result_count <= 0;
		end else begin
			errs = 0;
			if (start && !busy)
				expected_corr_q.push_back(compute_correlation(total_time, a_run_time,
					b_run_time, both_run_time));
			if (done) begin
				result_count <= result_count + 1;
				if (expected_corr_q.size() == 0) begin
					$error("unexpected result beat: correlation %0d", correlation);
					errs++;
				end else begin
					e = expected_corr_q.pop_front();
					if (correlation !== e.corr) begin
						$error("correlation: expected %0d, actual %0d",
							$signed(e.corr), correlation);
						errs++;
					end
					if (clamped !== e.clip) begin
						$error("clamped: expected %0b, actual %0b", e.clip, clamped);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

// ===== tb/sv/binary_run_correlation_test.sv =====
// Testbench top: drives count beats into the correlation pipe and reports the verdict.
module binary_run_correlation_test;
	import brc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] total_time = '0;
	logic [31:0] a_run_time = '0;
	logic [31:0] b_run_time = '0;
	logic [31:0] both_run_time = '0;
	logic        done;
	logic signed [CW-1:0] correlation;
	logic        clamped;
	int          fail_count, pending_count, result_count;
	int          beat_count = 0;

	always #5 clk = ~clk;

	binary_run_correlation DUT (.*);

	brc_checker u_checker (.*);

	// Offer one beat; hold it until it is taken (busy should stay low).
	task automatic send_beat(logic [31:0] t, logic [31:0] a, logic [31:0] b,
		logic [31:0] ab, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		total_time    <= t;
		a_run_time    <= a;
		b_run_time    <= b;
		both_run_time <= ab;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Random count in a random magnitude band so small and full-width values both show up.
	function automatic logic [31:0] rand_count();
		int sh;
		sh = $urandom_range(31);
		return $urandom() >> sh;
	endfunction

	// Mostly consistent counts: a, b <= t, ab within overlap bounds; some noise.
	task automatic send_random(int idle_pct);
		logic [31:0] t, a, b, ab, lo, hi;
		int mode;
		mode = $urandom_range(99);
		t = rand_count();
		if (mode < 80 && t > 2) begin
			a = $urandom_range(t);
			b = $urandom_range(t);
			lo = (64'(a) + b > t) ? a + b - t : 0;
			hi = (a < b) ? a : b;
			ab = (hi >= lo) ? lo + ($urandom() % (64'(hi - lo) + 1)) : lo;
		end else if (mode < 90) begin
			a = $urandom();
			b = $urandom();
			ab = $urandom();
			t = $urandom();
		end else begin
			a = rand_count();
			b = rand_count();
			ab = rand_count();
		end
		send_beat(t, a, b, ab, idle_pct);
		beat_count++;
	endtask

	initial begin
		int drain;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: degenerate indicators, extremes, ties, inconsistent overlap.
		send_beat(0, 0, 0, 0, 0);
		send_beat(100, 0, 50, 0, 0);
		send_beat(100, 50, 0, 0, 0);
		send_beat(100, 100, 50, 50, 0);
		send_beat(100, 50, 100, 50, 0);
		send_beat(100, 50, 50, 50, 0);     // perfect +1
		send_beat(100, 50, 50, 0, 0);      // perfect -1
		send_beat(100, 50, 50, 25, 0);     // zero
		send_beat(100, 30, 40, 35, 0);     // overlap beyond min
		send_beat(100, 200, 50, 50, 0);    // run time beyond total
		send_beat(100, 50, 200, 0, 0);
		send_beat(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		send_beat(32'hFFFFFFFF, 32'hFFFFFFFE, 32'h1, 32'h0, 0);
		send_beat(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h3FFFFFFF, 0);
		send_beat(32'hFFFFFFFE, 32'h1, 32'h1, 32'h1, 0);
		send_beat(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 0);
		send_beat(3, 1, 2, 1, 0);
		send_beat(3, 2, 1, 0, 0);
		send_beat(4, 2, 2, 1, 0);
		send_beat(2, 1, 1, 1, 0);
		send_beat(32'h55555555, 32'hAAAAAAAA, 32'h2AAAAAAA, 32'hD5555555, 0);
		beat_count = 21;

		// Random phases: sender idles 16%, then 59%, then never.
		repeat (550) send_random(16);
		repeat (550) send_random(59);
		repeat (550) send_random(0);
		start <= 1'b0;

		drain = 0;
		while (pending_count != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d count beats (directed extremes plus random bands), %0d results.",
			beat_count, result_count);
		if (fail_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
